### rtl/ldtm_pkg.sv
// ============================================================================
// ldtm_pkg: shared types and constants for the log-density tone mapper
// Fixed-point widths, operation codes, sequencer states and the request and
// response bundles of the shared arithmetic unit.
// ============================================================================
package ldtm_pkg;

   // Word field widths
   localparam int COUNT_BITS      = 32;
   localparam int SUM_BITS        = 40;
   localparam int COLOR_FRAC_BITS = 8;
   localparam int LOG_FRAC_BITS   = 16;
   localparam int CHAN_BITS       = 8;
   localparam int NUM_CHAN        = 3;
   localparam int CH_BITS         = $clog2(NUM_CHAN);

   // Derived fixed-point formats
   localparam int SCALE_BITS  = COLOR_FRAC_BITS + LOG_FRAC_BITS; // color * bright scale
   localparam int HIGH_BITS   = SUM_BITS - SCALE_BITS;           // sum bits above the quotient
   localparam int EXP_BITS    = $clog2(COUNT_BITS);              // integer part of log2
   localparam int LOG_BITS    = EXP_BITS + LOG_FRAC_BITS;
   localparam int BRIGHT_BITS = LOG_FRAC_BITS + 1;               // 0 .. 1.0 inclusive
   localparam int STEP_BITS   = $clog2(SCALE_BITS);

   // Shared unit operand widths
   localparam int MANT_BITS  = COUNT_BITS;      // Q1.31 mantissa
   localparam int ALU_B_BITS = COUNT_BITS;
   localparam int ALU_A_BITS = COUNT_BITS + 1;  // trial remainder carries one extra bit
   localparam int PROD_BITS  = 2 * ALU_B_BITS;

   localparam logic [CHAN_BITS-1:0]   CHAN_MAX   = 8'hFF;
   localparam logic [BRIGHT_BITS-1:0] BRIGHT_ONE = BRIGHT_BITS'(1) << LOG_FRAC_BITS;
   localparam logic [EXP_BITS-1:0]    NORM_FIRST = EXP_BITS'(COUNT_BITS / 2);
   localparam logic [EXP_BITS-1:0]    EXP_TOP    = EXP_BITS'(COUNT_BITS - 1);

   // Item kind carried in tuser
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_MAP  = 1'b1;

   typedef enum logic [1:0] {
      ALU_MUL,      // full product
      ALU_SQUARE,   // square Q1.31 mantissa, renormalize, emit log bit
      ALU_DIVSTEP,  // restoring division step, emit quotient bit
      ALU_NORM      // conditional left shift of a leading-zero search
   } alu_op_type;

   typedef struct packed {
      alu_op_type            op;
      logic [ALU_A_BITS-1:0] opa;
      logic [ALU_B_BITS-1:0] opb;
   } alu_req_type;

   typedef struct packed {
      logic [PROD_BITS-1:0] res;
      logic                 flag;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,   // take a word
      S_NORM,   // leading-one search, one shift size per cycle
      S_SQR,    // one log2 fraction bit per cycle
      S_BDIV,   // brightness quotient bits
      S_CPRE,   // channel quotient overflow check
      S_CDIV,   // channel quotient bits
      S_CMUL,   // color times brightness
      S_CSCL,   // times 255, keep top byte
      S_OUT     // load the result register
   } state_type;

endpackage

### rtl/ldtm_alu.sv
// ============================================================================
// ldtm_alu: shared arithmetic unit of the tone mapper
// One 32x32 multiplier, one subtract/compare and one masked shifter, selected
// per cycle by the sequencer. Purely combinational; callers register results.
// ============================================================================
module ldtm_alu (
   input  ldtm_pkg::alu_req_type alu_req,
   output ldtm_pkg::alu_rsp_type alu_rsp
);
   import ldtm_pkg::*;

   logic [PROD_BITS-1:0]  prod;
   logic [MANT_BITS:0]    sq_top;
   logic [ALU_A_BITS-1:0] diff;
   logic                  geq;
   logic [MANT_BITS-1:0]  norm_mask;
   logic [MANT_BITS-1:0]  norm_val;

   assign prod      = alu_req.opa[ALU_B_BITS-1:0] * alu_req.opb;
   // (y*y) >> 31 on a Q1.31 mantissa
   assign sq_top    = prod[2*MANT_BITS-1:MANT_BITS-1];
   assign geq       = alu_req.opa >= ALU_A_BITS'(alu_req.opb);
   assign diff      = alu_req.opa - ALU_A_BITS'(alu_req.opb);
   assign norm_val  = alu_req.opa[MANT_BITS-1:0];
   assign norm_mask = ~({MANT_BITS{1'b1}} >> alu_req.opb[EXP_BITS-1:0]);

   always_comb begin
      alu_rsp.res  = '0;
      alu_rsp.flag = 1'b0;
      case (alu_req.op)
         ALU_MUL: begin
            alu_rsp.res = prod;
         end
         ALU_SQUARE: begin
            alu_rsp.flag = sq_top[MANT_BITS];
            alu_rsp.res  = PROD_BITS'(sq_top[MANT_BITS] ? sq_top[MANT_BITS:1]
                                                       : sq_top[MANT_BITS-1:0]);
         end
         ALU_DIVSTEP: begin
            alu_rsp.flag = geq;
            alu_rsp.res  = PROD_BITS'(geq ? diff : alu_req.opa);
         end
         ALU_NORM: begin
            // top bits all zero: take the shift
            alu_rsp.flag = (norm_val & norm_mask) == '0;
            alu_rsp.res  = PROD_BITS'(alu_rsp.flag ?
                                      norm_val << alu_req.opb[EXP_BITS-1:0] : norm_val);
         end
         default: begin
            alu_rsp.res  = '0;
            alu_rsp.flag = 1'b0;
         end
      endcase
   end

endmodule

### rtl/log_density_tone_map.sv
// ============================================================================
// log_density_tone_map: log-density tone mapping of a hit-count histogram
// Scan words track the frame maximum; map words turn one cell into an RGB
// pixel through a sequencer driving one shared multiply/divide/shift unit.
// ============================================================================
//
// Channel  Dir  tdata (low bit up)                          tuser (low bit up)
// -------  ---  ------------------------------------------  -------------------
// req_     in   hit_count 32, red_sum 40, green_sum 40,     op 1, frame_start 1
//               blue_sum 40 (152 bits)
// rsp_     out  red_out 8, green_out 8, blue_out 8 (24 b)    -
//
// Sequence: a scan word is handled in the idle state. A map word with count <= 1
// or a frame maximum <= 1 goes straight to the output state. Otherwise a map word runs
//   log2 of the max (only after a scan or reset), log2 of the count,
//   the brightness divide (skipped when log2 of the count reaches log2 of the max),
//   per channel an overflow check, quotient bits, a multiply and a scale by 255
//   (the check alone when it already saturates the channel), then the output state.
// All steps share one multiplier/subtractor: one log bit, one quotient bit or one product a cycle.
// Reset clears the maximum to 1 and drops the cached log2 of the maximum.
// req_tready is high only while idle. A finished pixel waits in the output
// register; a new word is taken meanwhile, and its pixel is held back until
// the output register has been read.
//
module log_density_tone_map (
   input  logic                          clock,
   input  logic                          reset,
   // hit_count, red_sum, green_sum, blue_sum
   input  logic [151:0]                  req_tdata,
   // op, frame_start
   input  logic [1:0]                    req_tuser,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // red_out, green_out, blue_out
   output logic [23:0]                   rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready
);
   import ldtm_pkg::*;

   // ---------------------------------------------------------------- input view
   logic                  in_op;
   logic                  in_fs;
   logic [COUNT_BITS-1:0] in_count;
   logic [SUM_BITS-1:0]   in_sum [NUM_CHAN];
   logic                  req_fire;

   assign in_op     = req_tuser[0];
   assign in_fs     = req_tuser[1];
   assign in_count  = req_tdata[COUNT_BITS-1:0];
   assign in_sum[0] = req_tdata[COUNT_BITS +: SUM_BITS];
   assign in_sum[1] = req_tdata[COUNT_BITS + SUM_BITS +: SUM_BITS];
   assign in_sum[2] = req_tdata[COUNT_BITS + 2*SUM_BITS +: SUM_BITS];

   // ---------------------------------------------------------------- registers
   state_type                           state_ff,          state_in;
   logic [STEP_BITS-1:0]                step_ff,           step_in;
   logic                                tgt_max_ff,        tgt_max_in;   // log of max in flight
   logic [COUNT_BITS-1:0]               max_count_ff,      max_count_in;
   logic [LOG_BITS-1:0]                 log_max_ff,        log_max_in;
   logic                                log_max_valid_ff,  log_max_valid_in;
   logic [COUNT_BITS-1:0]               count_ff,          count_in;
   logic [SUM_BITS-1:0]                 sum_ff [NUM_CHAN];
   logic [SUM_BITS-1:0]                 sum_in [NUM_CHAN];
   logic [MANT_BITS-1:0]                wk_ff,             wk_in;        // mantissa
   logic [EXP_BITS-1:0]                 lz_ff,             lz_in;        // leading zeros
   logic [LOG_FRAC_BITS-1:0]            frac_ff,           frac_in;
   logic [ALU_A_BITS-1:0]               rem_ff,            rem_in;
   logic [SCALE_BITS-1:0]               quo_ff,            quo_in;
   logic [SCALE_BITS-1:0]               lo_ff,             lo_in;        // low sum bits
   logic [BRIGHT_BITS-1:0]              bright_ff,         bright_in;
   logic [CH_BITS-1:0]                  ch_ff,             ch_in;
   logic [NUM_CHAN-1:0][CHAN_BITS-1:0]  chan_ff,           chan_in;
   logic [NUM_CHAN-1:0][CHAN_BITS-1:0]  rsp_data_ff,       rsp_data_in;
   logic                                rsp_valid_ff,      rsp_valid_in;

   // ---------------------------------------------------------------- shared unit
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   ldtm_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // ---------------------------------------------------------------- helpers
   logic [LOG_FRAC_BITS-1:0] frac_next;
   logic [LOG_BITS-1:0]      log_val;
   logic [SCALE_BITS-1:0]    quo_next;
   logic [EXP_BITS-1:0]      norm_amt;
   logic                     last_ch;

   assign frac_next = {frac_ff[LOG_FRAC_BITS-2:0], alu_rsp.flag};
   assign log_val   = {EXP_TOP - lz_ff, frac_next};
   assign quo_next  = {quo_ff[SCALE_BITS-2:0], alu_rsp.flag};
   assign norm_amt  = NORM_FIRST >> step_ff;
   assign last_ch   = ch_ff == CH_BITS'(NUM_CHAN - 1);

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         max_count_ff     <= COUNT_BITS'(1);
         log_max_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         max_count_ff     <= max_count_in;
         log_max_valid_ff <= log_max_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      tgt_max_ff  <= tgt_max_in;
      log_max_ff  <= log_max_in;
      count_ff    <= count_in;
      sum_ff      <= sum_in;
      wk_ff       <= wk_in;
      lz_ff       <= lz_in;
      frac_ff     <= frac_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      lo_ff       <= lo_in;
      bright_ff   <= bright_in;
      ch_ff       <= ch_in;
      chan_ff     <= chan_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      tgt_max_in       = tgt_max_ff;
      max_count_in     = max_count_ff;
      log_max_in       = log_max_ff;
      log_max_valid_in = log_max_valid_ff;
      count_in         = count_ff;
      sum_in           = sum_ff;
      wk_in            = wk_ff;
      lz_in            = lz_ff;
      frac_in          = frac_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      lo_in            = lo_ff;
      bright_in        = bright_ff;
      ch_in            = ch_ff;
      chan_in          = chan_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      alu_req.op  = ALU_MUL;
      alu_req.opa = '0;
      alu_req.opb = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (in_op == OP_SCAN) begin
                  // frame_start restarts the max at 1 before the compare
                  if (in_fs) begin
                     max_count_in = (in_count > COUNT_BITS'(1)) ? in_count : COUNT_BITS'(1);
                  end else if (in_count > max_count_ff) begin
                     max_count_in = in_count;
                  end
                  log_max_valid_in = 1'b0;
               end else begin
                  count_in = in_count;
                  sum_in   = in_sum;
                  ch_in    = '0;
                  step_in  = '0;
                  lz_in    = '0;
                  if (in_count <= COUNT_BITS'(1) || max_count_ff <= COUNT_BITS'(1)) begin
                     // empty cell or flat frame: black pixel
                     chan_in  = '0;
                     state_in = S_OUT;
                  end else begin
                     tgt_max_in = !log_max_valid_ff;
                     wk_in      = log_max_valid_ff ? in_count : max_count_ff;
                     state_in   = S_NORM;
                  end
               end
            end
         end

         S_NORM: begin
            alu_req.op  = ALU_NORM;
            alu_req.opa = ALU_A_BITS'(wk_ff);
            alu_req.opb = ALU_B_BITS'(norm_amt);
            if (alu_rsp.flag) begin
               wk_in = alu_rsp.res[MANT_BITS-1:0];
               lz_in = lz_ff + norm_amt;
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(EXP_BITS - 1)) begin
               step_in  = '0;
               frac_in  = '0;
               state_in = S_SQR;
            end
         end

         S_SQR: begin
            alu_req.op  = ALU_SQUARE;
            alu_req.opa = ALU_A_BITS'(wk_ff);
            alu_req.opb = wk_ff;
            wk_in   = alu_rsp.res[MANT_BITS-1:0];
            frac_in = frac_next;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(LOG_FRAC_BITS - 1)) begin
               step_in = '0;
               if (tgt_max_ff) begin
                  // cache log2(max), then do the count
                  log_max_in       = log_val;
                  log_max_valid_in = 1'b1;
                  tgt_max_in       = 1'b0;
                  wk_in            = count_ff;
                  lz_in            = '0;
                  state_in         = S_NORM;
               end else if (log_val >= log_max_ff) begin
                  bright_in = BRIGHT_ONE;
                  state_in  = S_CPRE;
               end else begin
                  rem_in   = ALU_A_BITS'(log_val);
                  quo_in   = '0;
                  state_in = S_BDIV;
               end
            end
         end

         S_BDIV: begin
            // (log2(count) << LOG_FRAC_BITS) / log2(max), quotient below 1.0
            alu_req.op  = ALU_DIVSTEP;
            alu_req.opa = {rem_ff[ALU_B_BITS-1:0], 1'b0};
            alu_req.opb = ALU_B_BITS'(log_max_ff);
            rem_in  = alu_rsp.res[ALU_A_BITS-1:0];
            quo_in  = quo_next;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(LOG_FRAC_BITS - 1)) begin
               step_in   = '0;
               bright_in = BRIGHT_BITS'(quo_next[LOG_FRAC_BITS-1:0]);
               state_in  = S_CPRE;
            end
         end

         S_CPRE: begin
            // sum / count reaching 1.0 in color units saturates the channel
            alu_req.op  = ALU_DIVSTEP;
            alu_req.opa = ALU_A_BITS'(sum_ff[ch_ff][SUM_BITS-1:SCALE_BITS]);
            alu_req.opb = count_ff;
            lo_in   = sum_ff[ch_ff][SCALE_BITS-1:0];
            rem_in  = alu_rsp.res[ALU_A_BITS-1:0];
            quo_in  = '0;
            step_in = '0;
            if (alu_rsp.flag) begin
               chan_in[ch_ff] = CHAN_MAX;
               ch_in          = ch_ff + CH_BITS'(1);
               state_in       = last_ch ? S_OUT : S_CPRE;
            end else begin
               state_in = S_CDIV;
            end
         end

         S_CDIV: begin
            alu_req.op  = ALU_DIVSTEP;
            alu_req.opa = {rem_ff[ALU_B_BITS-1:0], lo_ff[SCALE_BITS-1]};
            alu_req.opb = count_ff;
            rem_in  = alu_rsp.res[ALU_A_BITS-1:0];
            quo_in  = quo_next;
            lo_in   = {lo_ff[SCALE_BITS-2:0], 1'b0};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SCALE_BITS - 1)) begin
               step_in  = '0;
               state_in = S_CMUL;
            end
         end

         S_CMUL: begin
            alu_req.op  = ALU_MUL;
            alu_req.opa = ALU_A_BITS'(quo_ff);
            alu_req.opb = ALU_B_BITS'(bright_ff);
            if (alu_rsp.res[PROD_BITS-1:SCALE_BITS] != '0) begin
               chan_in[ch_ff] = CHAN_MAX;
               ch_in          = ch_ff + CH_BITS'(1);
               state_in       = last_ch ? S_OUT : S_CPRE;
            end else begin
               quo_in   = alu_rsp.res[SCALE_BITS-1:0];
               state_in = S_CSCL;
            end
         end

         S_CSCL: begin
            // fraction times 255, top byte stays below 255
            alu_req.op  = ALU_MUL;
            alu_req.opa = ALU_A_BITS'(quo_ff);
            alu_req.opb = ALU_B_BITS'(CHAN_MAX);
            chan_in[ch_ff] = alu_rsp.res[SCALE_BITS + CHAN_BITS - 1:SCALE_BITS];
            ch_in          = ch_ff + CH_BITS'(1);
            state_in       = last_ch ? S_OUT : S_CPRE;
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = chan_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- checks
   a_scan_drops_log: assert property (@(posedge clock) disable iff (reset)
      (req_fire && in_op == OP_SCAN) |=> !log_max_valid_ff)
      else $error("cached log2 of max survived a scan word");

   a_log_max_sane: assert property (@(posedge clock) disable iff (reset)
      log_max_valid_ff |-> (max_count_ff > COUNT_BITS'(1) &&
                            log_max_ff[LOG_BITS-1:LOG_FRAC_BITS] != '0))
      else $error("cached log2 of max inconsistent with max");

   a_bdiv_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_BDIV |-> rem_ff < ALU_A_BITS'(log_max_ff))
      else $error("brightness remainder not below divisor");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result loaded outside output state");

endmodule
